[hw/rtl/gtfw_pkg.sv]
// Shared types, constants and the glyph table of the text framebuffer writer.
`timescale 1ns / 1ps

package gtfw_pkg;

   // Default panel geometry.
   localparam int PANEL_WIDTH_DEF  = 128;
   localparam int PANEL_HEIGHT_DEF = 64;

   // Glyph and cursor geometry.
   localparam int GLYPH_COLS = 5;
   localparam int GLYPH_STEP = 6;
   localparam int SPACE_STEP = 2;

   // Horizontal line span, first column and one past the last.
   localparam int LINE_FIRST = 10;
   localparam int LINE_END   = 115;

   // Character codes.
   localparam logic [7:0] CHAR_FIRST = 8'd65;
   localparam logic [7:0] CHAR_LAST  = 8'd91;
   localparam logic [7:0] CHAR_SPACE = 8'd32;

   // Byte value of a blank band.
   localparam logic [7:0] FILL_BYTE = 8'hFF;

   // Request codes.
   typedef enum logic [2:0] {
      REQ_SET_CURSOR = 3'd0,
      REQ_CHAR       = 3'd1,
      REQ_CLEAR      = 3'd2,
      REQ_READ       = 3'd3,
      REQ_LINE       = 3'd4
   } req_code_type;

   // One store access: the merge is applied to the byte it reads, in the cycle after it is issued.
   typedef struct packed {
      logic       write;
      logic [7:0] mask;
      logic [7:0] bits;
   } acc_type;

   // Glyph columns, bit r is row r, a set bit is a lit pixel.
   localparam logic [7:0] GLYPH_ROM [0:26][0:4] = '{
      '{8'h3F, 8'h48, 8'h48, 8'h48, 8'h3F},
      '{8'h36, 8'h49, 8'h49, 8'h49, 8'h7F},
      '{8'h41, 8'h41, 8'h41, 8'h41, 8'h3E},
      '{8'h1C, 8'h22, 8'h41, 8'h41, 8'h7F},
      '{8'h41, 8'h49, 8'h49, 8'h49, 8'h7F},
      '{8'h40, 8'h48, 8'h48, 8'h48, 8'h7F},
      '{8'h36, 8'h29, 8'h49, 8'h41, 8'h3E},
      '{8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F},
      '{8'h00, 8'h41, 8'h7F, 8'h41, 8'h00},
      '{8'h40, 8'h7F, 8'h41, 8'h41, 8'h02},
      '{8'h41, 8'h22, 8'h14, 8'h08, 8'h7F},
      '{8'h01, 8'h01, 8'h01, 8'h01, 8'h7F},
      '{8'h7F, 8'h10, 8'h08, 8'h10, 8'h7F},
      '{8'h7F, 8'h08, 8'h10, 8'h10, 8'h7F},
      '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E},
      '{8'h30, 8'h48, 8'h48, 8'h48, 8'h7F},
      '{8'h3D, 8'h45, 8'h41, 8'h41, 8'h3E},
      '{8'h33, 8'h4C, 8'h48, 8'h48, 8'h7F},
      '{8'h26, 8'h49, 8'h49, 8'h49, 8'h31},
      '{8'h40, 8'h40, 8'h7E, 8'h40, 8'h40},
      '{8'h7E, 8'h01, 8'h01, 8'h01, 8'h7E},
      '{8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F},
      '{8'h7F, 8'h10, 8'h20, 8'h10, 8'h7F},
      '{8'hC6, 8'h28, 8'h10, 8'h28, 8'hC6},
      '{8'hC0, 8'h90, 8'h87, 8'h90, 8'hC0},
      '{8'hC3, 8'hA5, 8'h92, 8'hA5, 8'hC1},
      '{8'h7F, 8'h41, 8'h41, 8'h41, 8'h7F}
   };

endpackage

[hw/rtl/gtfw_ifs.sv]
// Request and response channel interfaces of the text framebuffer writer.
`timescale 1ns / 1ps

interface gtfw_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] req_type;
   logic [6:0] pos_x;
   logic [5:0] pos_y;
   logic [7:0] char_code;
   logic [9:0] read_addr;

   modport source (output valid, req_type, pos_x, pos_y, char_code, read_addr,
                   input ready);
   modport sink (input valid, req_type, pos_x, pos_y, char_code, read_addr,
                 output ready);
endinterface

interface gtfw_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;

   modport source (output valid, read_data, input ready);
   modport sink (input valid, read_data, output ready);
endinterface

[hw/rtl/glyph_text_framebuffer_writer.sv]
// Top level of the text framebuffer writer.
`timescale 1ns / 1ps

// Usage:
// Requests arrive on req_chan (valid/ready); an item is taken when both are
// high. Set-cursor, character, clear and line items give no response. A read
// item returns one framebuffer byte on rsp_chan, bit n being row n of the band,
// 0 meaning lit.
// Timing: set-cursor, space and ignored codes leave the block ready for the next
// item. A character makes ten read-modify-write accesses (five columns by two
// bands), one per cycle through the single store read port, after its accept
// cycle. A line makes one access per column 10..114. A clear sweeps the store
// one byte per cycle, PANEL_WIDTH * ceil(PANEL_HEIGHT / 8) bytes, 1024 at
// 128x64. A read passes an issue and a data state; its response is registered.
// Reset: the cursor goes to zero and the store is swept to all ones, all
// PANEL_WIDTH * ceil(PANEL_HEIGHT / 8) bytes (1024 at 128x64); no item is
// taken during the sweep.
// Stall: the response sits in an output register; non-read items keep being
// taken, and a further read, once taken, holds the block until it can respond.
module glyph_text_framebuffer_writer #(
   parameter int PANEL_WIDTH  = gtfw_pkg::PANEL_WIDTH_DEF,
   parameter int PANEL_HEIGHT = gtfw_pkg::PANEL_HEIGHT_DEF
) (
   input  logic       clock,
   input  logic       reset,
   gtfw_req_if.sink   req_chan,
   gtfw_rsp_if.source rsp_chan
);

   localparam int STORE_BYTES = PANEL_WIDTH * ((PANEL_HEIGHT + 7) / 8);
   localparam int ADDR_W = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

   gtfw_pkg::acc_type acc;
   logic [ADDR_W-1:0] acc_addr;
   logic [7:0]        rd_data;

   // Sequencer generates one store access per cycle.
   gtfw_seq #(
      .PANEL_WIDTH  (PANEL_WIDTH),
      .PANEL_HEIGHT (PANEL_HEIGHT)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .rd_data  (rd_data),
      .acc_out  (acc),
      .acc_addr (acc_addr)
   );

   // Store with its merge stage.
   gtfw_store #(
      .DEPTH (STORE_BYTES)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .acc_in   (acc),
      .acc_addr (acc_addr),
      .rd_data  (rd_data)
   );

endmodule

[hw/rtl/gtfw_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module gtfw_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write first in program order; a read of the address written in the same
   // cycle returns the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/gtfw_store.sv]
// Framebuffer store: the RAM plus the merge stage of the read-modify-write path.
`timescale 1ns / 1ps

module gtfw_store #(
   parameter int DEPTH = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  gtfw_pkg::acc_type   acc_in,
   input  logic [ADDR_W-1:0]   acc_addr,
   output logic [7:0]          rd_data
);

   gtfw_pkg::acc_type pend_ff;
   gtfw_pkg::acc_type pend_in;
   logic [ADDR_W-1:0] pend_addr_ff;
   logic [7:0]        merge_data;

   // The access issued this cycle is merged when its read data returns.
   always_comb begin
      pend_in = acc_in;
      if (reset) begin
         pend_in.write = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff      <= pend_in;
      pend_addr_ff <= acc_addr;
   end

   // Masked bits take the new value, the others keep the stored byte.
   assign merge_data = (rd_data & ~pend_ff.mask) | (pend_ff.bits & pend_ff.mask);

   gtfw_ram #(
      .DATA_W (8),
      .DEPTH  (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (pend_ff.write),
      .wr_addr (pend_addr_ff),
      .wr_data (merge_data),
      .rd_addr (acc_addr),
      .rd_data (rd_data)
   );

endmodule

[hw/rtl/gtfw_seq.sv]
// Request sequencer: cursor, access generation for glyphs, lines and clears, reads.
`timescale 1ns / 1ps

module gtfw_seq #(
   parameter int PANEL_WIDTH  = gtfw_pkg::PANEL_WIDTH_DEF,
   parameter int PANEL_HEIGHT = gtfw_pkg::PANEL_HEIGHT_DEF,
   localparam int STORE_BYTES = PANEL_WIDTH * ((PANEL_HEIGHT + 7) / 8),
   localparam int ADDR_W = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1
) (
   input  logic              clock,
   input  logic              reset,
   gtfw_req_if.sink          req_chan,
   gtfw_rsp_if.source        rsp_chan,
   input  logic [7:0]        rd_data,
   output gtfw_pkg::acc_type acc_out,
   output logic [ADDR_W-1:0] acc_addr
);

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_CLEAR    = 6'b000010,
      ST_GLYPH    = 6'b000100,
      ST_LINE     = 6'b001000,
      ST_RD_ISSUE = 6'b010000,
      ST_RD_DATA  = 6'b100000
   } state_type;

   localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(STORE_BYTES - 1);
   localparam logic [ADDR_W-1:0] ADDR_ONE   = ADDR_W'(1);
   localparam logic [2:0]        LAST_COL   = 3'(gtfw_pkg::GLYPH_COLS - 1);
   localparam logic [6:0]        LINE_LAST  = 7'(gtfw_pkg::LINE_END - 1);
   localparam logic [6:0]        GLYPH_MOVE = 7'(gtfw_pkg::GLYPH_STEP);
   localparam logic [6:0]        SPACE_MOVE = 7'(gtfw_pkg::SPACE_STEP);

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic [6:0]        col_ff, col_in;
   logic [5:0]        row_ff, row_in;
   logic [4:0]        glyph_ff, glyph_in;
   logic [2:0]        gk_ff, gk_in;
   logic              band_ff, band_in;
   logic [6:0]        line_x_ff, line_x_in;
   logic [5:0]        line_y_ff, line_y_in;
   logic [ADDR_W-1:0] rd_addr_ff, rd_addr_in;
   logic              rd_ok_ff, rd_ok_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_data_ff, rsp_data_in;

   logic              accept;
   logic              rsp_take;
   logic [7:0]        gcol;
   logic [15:0]       g_sh;
   logic [15:0]       m_sh;
   logic [3:0]        band_idx;
   logic [6:0]        band_row;
   logic [7:0]        row_ok;
   logic [8:0]        gx;
   logic              gx_ok;
   logic [7:0]        g_mask;
   logic [ADDR_W-1:0] g_addr;
   logic              lx_ok;
   logic              ly_ok;
   logic [ADDR_W-1:0] l_addr;

   assign accept   = req_chan.valid && req_chan.ready;
   assign rsp_take = rsp_valid_ff && rsp_chan.ready;

   assign req_chan.ready     = (state_ff == ST_IDLE);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.read_data = rsp_data_ff;

   // Glyph column placed at the cursor row offset across two byte bands.
   always_comb begin
      gcol     = gtfw_pkg::GLYPH_ROM[glyph_ff][gk_ff];
      g_sh     = {9'd0, gcol[6:0]} << row_ff[2:0];
      m_sh     = 16'h007F << row_ff[2:0];
      band_idx = {1'b0, row_ff[5:3]} + {3'd0, band_ff};
      band_row = {band_idx, 3'b000};
      for (int i = 0; i < 8; i++) begin
         row_ok[i] = ({1'b0, band_row} + 8'(i)) < 8'(PANEL_HEIGHT);
      end
      gx     = {2'd0, col_ff} + {6'd0, gk_ff};
      gx_ok  = gx < 9'(PANEL_WIDTH);
      g_mask = (band_ff ? m_sh[15:8] : m_sh[7:0]) & row_ok;
      g_addr = ADDR_W'(32'(gx) + 32'(band_idx) * 32'(PANEL_WIDTH));
   end

   // Line pixel at the current column.
   always_comb begin
      lx_ok  = {2'd0, line_x_ff} < 9'(PANEL_WIDTH);
      ly_ok  = {2'd0, line_y_ff} < 8'(PANEL_HEIGHT);
      l_addr = ADDR_W'(32'(line_x_ff) + 32'(line_y_ff[5:3]) * 32'(PANEL_WIDTH));
   end

   // Access issued to the store in each state.
   always_comb begin
      acc_out.write = 1'b0;
      acc_out.mask  = 8'd0;
      acc_out.bits  = 8'd0;
      acc_addr      = '0;
      unique case (state_ff) inside
         ST_CLEAR: begin
            acc_out.write = 1'b1;
            acc_out.mask  = gtfw_pkg::FILL_BYTE;
            acc_out.bits  = gtfw_pkg::FILL_BYTE;
            acc_addr      = clr_cnt_ff;
         end
         ST_GLYPH: begin
            acc_out.write = gx_ok && (g_mask != 8'd0);
            acc_out.mask  = g_mask;
            acc_out.bits  = ~(band_ff ? g_sh[15:8] : g_sh[7:0]);
            acc_addr      = g_addr;
         end
         ST_LINE: begin
            acc_out.write = lx_ok && ly_ok;
            acc_out.mask  = 8'd1 << line_y_ff[2:0];
            acc_out.bits  = 8'd0;
            acc_addr      = l_addr;
         end
         ST_RD_ISSUE, ST_RD_DATA: begin
            acc_addr = rd_addr_ff;
         end
         ST_IDLE: begin
            acc_addr = '0;
         end
         default: begin
            acc_addr = '0;
         end
      endcase
   end

   // Request decode and sequencing.
   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      glyph_in     = glyph_ff;
      gk_in        = gk_ff;
      band_in      = band_ff;
      line_x_in    = line_x_ff;
      line_y_in    = line_y_ff;
      rd_addr_in   = rd_addr_ff;
      rd_ok_in     = rd_ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_take;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_chan.req_type)
                  gtfw_pkg::REQ_SET_CURSOR: begin
                     col_in = req_chan.pos_x;
                     row_in = req_chan.pos_y;
                  end
                  gtfw_pkg::REQ_CHAR: begin
                     if (req_chan.char_code >= gtfw_pkg::CHAR_FIRST &&
                         req_chan.char_code <= gtfw_pkg::CHAR_LAST) begin
                        glyph_in = 5'(req_chan.char_code - gtfw_pkg::CHAR_FIRST);
                        gk_in    = 3'd0;
                        band_in  = 1'b0;
                        state_in = ST_GLYPH;
                     end else if (req_chan.char_code == gtfw_pkg::CHAR_SPACE) begin
                        col_in = (col_ff > SPACE_MOVE) ? col_ff - SPACE_MOVE : 7'd0;
                     end
                  end
                  gtfw_pkg::REQ_CLEAR: begin
                     clr_cnt_in = '0;
                     state_in   = ST_CLEAR;
                  end
                  gtfw_pkg::REQ_READ: begin
                     rd_addr_in = ADDR_W'(req_chan.read_addr);
                     rd_ok_in   = 32'(req_chan.read_addr) < 32'(STORE_BYTES);
                     state_in   = ST_RD_ISSUE;
                  end
                  gtfw_pkg::REQ_LINE: begin
                     line_x_in = 7'(gtfw_pkg::LINE_FIRST);
                     line_y_in = req_chan.pos_y;
                     state_in  = ST_LINE;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + ADDR_ONE;
            if (clr_cnt_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_GLYPH: begin
            // Two bands per column, then the next column; the cursor moves at the end.
            band_in = ~band_ff;
            if (band_ff) begin
               gk_in = gk_ff + 3'd1;
               if (gk_ff == LAST_COL) begin
                  col_in   = (col_ff > GLYPH_MOVE) ? col_ff - GLYPH_MOVE : 7'd0;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_LINE: begin
            line_x_in = line_x_ff + 7'd1;
            if (line_x_ff == LINE_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_RD_ISSUE: begin
            state_in = ST_RD_DATA;
         end
         ST_RD_DATA: begin
            // The read address is held, so the RAM output stays valid while stalled.
            if (!rsp_valid_ff || rsp_take) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = rd_ok_ff ? rd_data : 8'd0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state; after reset the store is swept to blank.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         col_ff       <= 7'd0;
         row_ff       <= 6'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Item payload.
   always_ff @(posedge clock) begin
      glyph_ff    <= glyph_in;
      gk_ff       <= gk_in;
      band_ff     <= band_in;
      line_x_ff   <= line_x_in;
      line_y_ff   <= line_y_in;
      rd_addr_ff  <= rd_addr_in;
      rd_ok_ff    <= rd_ok_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

[test/glyph_text_framebuffer_writer_tb.sv]
// Self-checking testbench of the text framebuffer writer, with its own pixel-level store model.
`timescale 1ns / 1ps

module glyph_text_framebuffer_writer_tb;
   import gtfw_pkg::*;

   localparam int CLK_PERIOD    = 8;
   localparam int RESET_CYCLES  = 7;
   localparam int PANEL_W       = PANEL_WIDTH_DEF;
   localparam int PANEL_H       = PANEL_HEIGHT_DEF;
   localparam int STORE_BYTES   = PANEL_W * ((PANEL_H + 7) / 8);
   localparam int GLYPH_ROWS    = 7;
   localparam int IDLE_PCT      = 9;
   localparam int RANDOM_ITEMS  = 750;
   localparam int STEADY_FIRST  = 350;
   localparam int STEADY_LAST   = 500;
   localparam int HOLD_AT       = 225;
   localparam int HOLD_CYCLES   = 600;
   // A clear sweeps the whole store, the longest thing the block does.
   localparam int DRAIN_CYCLES  = 1100;
   localparam int TIMEOUT_NS    = 8_000_000;

   // Request type codes the block ignores.
   localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
   localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

   // Font columns, bit r is row r of the glyph, a set bit is lit.
   localparam logic [7:0] GLYPH_COLUMNS [0:26][0:4] = '{
      '{8'h3F, 8'h48, 8'h48, 8'h48, 8'h3F},
      '{8'h36, 8'h49, 8'h49, 8'h49, 8'h7F},
      '{8'h41, 8'h41, 8'h41, 8'h41, 8'h3E},
      '{8'h1C, 8'h22, 8'h41, 8'h41, 8'h7F},
      '{8'h41, 8'h49, 8'h49, 8'h49, 8'h7F},
      '{8'h40, 8'h48, 8'h48, 8'h48, 8'h7F},
      '{8'h36, 8'h29, 8'h49, 8'h41, 8'h3E},
      '{8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F},
      '{8'h00, 8'h41, 8'h7F, 8'h41, 8'h00},
      '{8'h40, 8'h7F, 8'h41, 8'h41, 8'h02},
      '{8'h41, 8'h22, 8'h14, 8'h08, 8'h7F},
      '{8'h01, 8'h01, 8'h01, 8'h01, 8'h7F},
      '{8'h7F, 8'h10, 8'h08, 8'h10, 8'h7F},
      '{8'h7F, 8'h08, 8'h10, 8'h10, 8'h7F},
      '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E},
      '{8'h30, 8'h48, 8'h48, 8'h48, 8'h7F},
      '{8'h3D, 8'h45, 8'h41, 8'h41, 8'h3E},
      '{8'h33, 8'h4C, 8'h48, 8'h48, 8'h7F},
      '{8'h26, 8'h49, 8'h49, 8'h49, 8'h31},
      '{8'h40, 8'h40, 8'h7E, 8'h40, 8'h40},
      '{8'h7E, 8'h01, 8'h01, 8'h01, 8'h7E},
      '{8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F},
      '{8'h7F, 8'h10, 8'h20, 8'h10, 8'h7F},
      '{8'hC6, 8'h28, 8'h10, 8'h28, 8'hC6},
      '{8'hC0, 8'h90, 8'h87, 8'h90, 8'hC0},
      '{8'hC3, 8'hA5, 8'h92, 8'hA5, 8'hC1},
      '{8'h7F, 8'h41, 8'h41, 8'h41, 8'h7F}
   };

   typedef struct packed {
      logic [2:0] kind;
      logic [6:0] px;
      logic [5:0] py;
      logic [7:0] code;
      logic [9:0] addr;
   } draw_req_type;

   // One line of the directed plan; typed rows carry a fixed read value.
   typedef struct packed {
      draw_req_type item;
      logic         typed;
      logic [7:0]   want;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   gtfw_req_if req_chan ();
   gtfw_rsp_if rsp_chan ();

   glyph_text_framebuffer_writer u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Shadow of the panel and its cursor.
   logic [7:0] frame_img [0:STORE_BYTES-1];
   logic [9:0] cur_col;
   logic [5:0] cur_row;

   logic [7:0]   read_bytes_due [$];
   plan_row_type directed_plan [$];
   int           mismatch_count = 0;
   int           sent_count = 0;
   bit           steady = 1'b0;
   bit           hold_done = 1'b0;
   int           hold_left = 0;
   logic [7:0]   due_byte;

   always #(CLK_PERIOD / 2) clock = ~clock;

   task automatic report_error(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatch_count++;
   endtask

   function automatic void plot(input int x, input int y, input bit lit);
      int idx;
      if (x >= PANEL_W || y >= PANEL_H) return;
      idx = x + (y / 8) * PANEL_W;
      frame_img[idx][y % 8] = ~lit;
   endfunction

   function automatic logic [9:0] step_left(input logic [9:0] c, input int s);
      return (int'(c) > s) ? c - 10'(s) : 10'd0;
   endfunction

   // Applies one accepted item to the shadow; a read hands back its byte.
   function automatic void model_request(input draw_req_type it, output bit gives,
                                         output logic [7:0] byte_out);
      logic [7:0] col_bits;
      gives = 1'b0;
      byte_out = '0;
      case (it.kind)
         REQ_SET_CURSOR: begin
            cur_col = {3'b000, it.px};
            cur_row = it.py;
         end
         REQ_CHAR: begin
            if (it.code >= CHAR_FIRST && it.code <= CHAR_LAST) begin
               for (int k = 0; k < GLYPH_COLS; k++) begin
                  col_bits = GLYPH_COLUMNS[it.code - CHAR_FIRST][k];
                  for (int r = 0; r < GLYPH_ROWS; r++)
                     plot(int'(cur_col) + k, int'(cur_row) + r, col_bits[r]);
               end
               cur_col = step_left(cur_col, GLYPH_STEP);
            end else if (it.code == CHAR_SPACE) begin
               cur_col = step_left(cur_col, SPACE_STEP);
            end
         end
         REQ_CLEAR: begin
            for (int i = 0; i < STORE_BYTES; i++) frame_img[i] = FILL_BYTE;
         end
         REQ_READ: begin
            gives = 1'b1;
            byte_out = (int'(it.addr) < STORE_BYTES) ? frame_img[it.addr] : 8'h00;
         end
         REQ_LINE: begin
            for (int x = LINE_FIRST; x < LINE_END; x++) plot(x, int'(it.py), 1'b1);
         end
         default: ;
      endcase
   endfunction

   // Mostly well-formed drawing traffic; reads lean toward the cursor area.
   function automatic draw_req_type random_request();
      draw_req_type r;
      int pick;
      int band;
      int col;
      r.kind = 3'($urandom_range(0, 7));
      r.px   = 7'($urandom);
      r.py   = 6'($urandom);
      r.code = 8'($urandom);
      r.addr = 10'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         r.kind = REQ_SET_CURSOR;
      end else if (pick < 58) begin
         r.kind = REQ_CHAR;
         pick = $urandom_range(0, 99);
         if (pick < 80) r.code = 8'($urandom_range(CHAR_FIRST, CHAR_LAST));
         else if (pick < 88) r.code = CHAR_SPACE;
      end else if (pick < 88) begin
         r.kind = REQ_READ;
         if ($urandom_range(0, 1) == 1) begin
            band = int'(cur_row) / 8 + $urandom_range(0, 1);
            if (band > PANEL_H / 8 - 1) band = PANEL_H / 8 - 1;
            col = int'(cur_col) + $urandom_range(0, 11);
            if (col > PANEL_W - 1) col = PANEL_W - 1;
            r.addr = 10'(band * PANEL_W + col);
         end
      end else if (pick < 94) begin
         r.kind = REQ_LINE;
      end else if (pick < 95) begin
         r.kind = REQ_CLEAR;
      end else begin
         r.kind = 3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
      end
      return r;
   endfunction

   // Offers one item from a falling edge and holds it until it is taken.
   task automatic offer_request(input draw_req_type it);
      @(negedge clock);
      while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.req_type  <= it.kind;
      req_chan.pos_x     <= it.px;
      req_chan.pos_y     <= it.py;
      req_chan.char_code <= it.code;
      req_chan.read_addr <= it.addr;
      do @(posedge clock); while (!req_chan.ready);
      sent_count++;
   endtask

   task automatic add_row(input logic [2:0] kind, input logic [6:0] px, input logic [5:0] py,
                          input logic [7:0] code, input logic [9:0] addr,
                          input logic typed, input logic [7:0] want);
      plan_row_type row;
      row.item = '{kind: kind, px: px, py: py, code: code, addr: addr};
      row.typed = typed;
      row.want = want;
      directed_plan.push_back(row);
   endtask

   // Receiver: random stalls, plus one long hold-off while requests keep coming.
   always @(negedge clock) begin
      if (!hold_done && sent_count >= HOLD_AT) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // Each taken response must match the oldest outstanding read.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (read_bytes_due.size() == 0) begin
            report_error($sformatf("response %02h with no read outstanding",
                                   rsp_chan.read_data));
         end else begin
            due_byte = read_bytes_due.pop_front();
            if (rsp_chan.read_data !== due_byte)
               report_error($sformatf("read_data %02h, expected %02h",
                                      rsp_chan.read_data, due_byte));
         end
      end
   end

   // Hard stop in case the block hangs.
   initial begin
      #(TIMEOUT_NS);
      $display("glyph_text_framebuffer_writer_tb: FAIL");
      $finish;
   end

   initial begin
      bit           gives;
      logic [7:0]   predicted;
      draw_req_type it;

      req_chan.valid     = 1'b0;
      req_chan.req_type  = '0;
      req_chan.pos_x     = '0;
      req_chan.pos_y     = '0;
      req_chan.char_code = '0;
      req_chan.read_addr = '0;
      rsp_chan.ready     = 1'b0;
      for (int i = 0; i < STORE_BYTES; i++) frame_img[i] = FILL_BYTE;
      cur_col = '0;
      cur_row = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed plan: reset contents, line ends, clear, glyph edges and
      // cursor saturation, off-panel pixels, space, ignored codes and types.
      add_row(REQ_READ, 7'd0, 6'd0, 8'd0, 10'd0, 1'b1, FILL_BYTE);
      add_row(REQ_READ, 7'd0, 6'd0, 8'd0, 10'd1023, 1'b1, FILL_BYTE);
      add_row(REQ_LINE, 7'd0, 6'd0, 8'd0, 10'd0, 1'b0, 8'h00);
      add_row(REQ_READ, 7'd0, 6'd0, 8'd0, 10'd10, 1'b1, 8'hFE);
      add_row(REQ_READ, 7'd0, 6'd0, 8'd0, 10'd9, 1'b1, FILL_BYTE);
      add_row(REQ_READ, 7'd0, 6'd0, 8'd0, 10'd114, 1'b1, 8'hFE);
      add_row(REQ_READ, 7'd0, 6'd0, 8'd0, 10'd115, 1'b1, FILL_BYTE);
      add_row(REQ_LINE, 7'd0, 6'd63, 8'd0, 10'd0, 1'b0, 8'h00);
      add_row(REQ_READ, 7'd0, 6'd0, 8'd0, 10'd1010, 1'b1, 8'h7F);
      add_row(REQ_CLEAR, 7'd0, 6'd0, 8'd0, 10'd0, 1'b0, 8'h00);
      add_row(REQ_READ, 7'd0, 6'd0, 8'd0, 10'd1010, 1'b1, FILL_BYTE);
      add_row(REQ_SET_CURSOR, 7'd0, 6'd0, 8'd0, 10'd0, 1'b0, 8'h00);
      add_row(REQ_CHAR, 7'd0, 6'd0, CHAR_FIRST, 10'd0, 1'b0, 8'h00);
      add_row(REQ_READ, 7'd0, 6'd0, 8'd0, 10'd0, 1'b0, 8'h00);
      add_row(REQ_CHAR, 7'd0, 6'd0, 8'd90, 10'd0, 1'b0, 8'h00);
      add_row(REQ_READ, 7'd0, 6'd0, 8'd0, 10'd2, 1'b0, 8'h00);
      add_row(REQ_SET_CURSOR, 7'd127, 6'd63, 8'd0, 10'd0, 1'b0, 8'h00);
      add_row(REQ_CHAR, 7'd0, 6'd0, CHAR_LAST, 10'd0, 1'b0, 8'h00);
      add_row(REQ_READ, 7'd0, 6'd0, 8'd0, 10'd1023, 1'b0, 8'h00);
      add_row(REQ_CHAR, 7'd0, 6'd0, CHAR_SPACE, 10'd0, 1'b0, 8'h00);
      add_row(REQ_CHAR, 7'd0, 6'd0, 8'd0, 10'd0, 1'b0, 8'h00);
      add_row(REQ_CHAR, 7'd0, 6'd0, 8'd255, 10'd0, 1'b0, 8'h00);
      add_row(REQ_UNUSED_HI, 7'd127, 6'd63, 8'd255, 10'd1023, 1'b0, 8'h00);
      add_row(REQ_SET_CURSOR, 7'd60, 6'd5, 8'd0, 10'd0, 1'b0, 8'h00);
      add_row(REQ_CHAR, 7'd0, 6'd0, 8'd77, 10'd0, 1'b0, 8'h00);
      add_row(REQ_READ, 7'd0, 6'd0, 8'd0, 10'd60, 1'b0, 8'h00);
      add_row(REQ_READ, 7'd0, 6'd0, 8'd0, 10'd188, 1'b0, 8'h00);

      foreach (directed_plan[i]) begin
         offer_request(directed_plan[i].item);
         model_request(directed_plan[i].item, gives, predicted);
         if (gives)
            read_bytes_due.push_back(directed_plan[i].typed ? directed_plan[i].want
                                                            : predicted);
      end

      // Random traffic, with one stretch where neither side idles.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         steady = (i >= STEADY_FIRST && i < STEADY_LAST);
         it = random_request();
         offer_request(it);
         model_request(it, gives, predicted);
         if (gives) read_bytes_due.push_back(predicted);
      end
      steady = 1'b0;
      @(negedge clock);
      req_chan.valid <= 1'b0;

      // Let outstanding reads and any last sweep finish.
      while (read_bytes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("glyph_text_framebuffer_writer_tb: PASS");
      end else begin
         $display("glyph_text_framebuffer_writer_tb: FAIL");
      end
      $finish;
   end

endmodule

[glyph_text_framebuffer_writer.f]
hw/rtl/gtfw_pkg.sv
hw/rtl/gtfw_ifs.sv
hw/rtl/gtfw_ram.sv
hw/rtl/gtfw_store.sv
hw/rtl/gtfw_seq.sv
hw/rtl/glyph_text_framebuffer_writer.sv
test/glyph_text_framebuffer_writer_tb.sv
